[rtl/dda_pkg.sv]
package dda_pkg;

    // Field widths as seen on the stream ports
    localparam int SAMPLE_FIELD_W = 12;
    localparam int DENS_W         = 15;
    localparam int CFG_W          = 8;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 32;
    localparam int OUT_TUSER_W    = 1;

    // Density per count, times 2^ADC_BITS, in 1/16 ug/m3 (3.3 V * 100 * 16 * 4)
    localparam int DENSITY_SCALE  = 21120;
    localparam int SCALE_W        = 15;
    // Floor density when the mean sits at or below the baseline (about 0.1 ug/m3)
    localparam int DENSITY_FLOOR  = 2;
    // Samples per reading after reset
    localparam int SPR_RESET      = 10;

endpackage

[rtl/dust_density_averager.sv]
// Path: a burst-completing word runs the mean division, the baseline compare, a multiply
//   step above the baseline, the window push, the average division, then the output step.
// Throughput: a word that does not complete a burst is taken every cycle; a burst-completing
//   word holds off s_axis until its result is loaded; the shared divider is one-bit-per-cycle.
// Reset: asynchronous, active low; clears the burst, the window fill and sum, sets the
//   baseline to 0.25 V in counts and the burst length to 10. Window entries are not cleared.
module dust_density_averager
    import dda_pkg::*;
#(
    parameter int WINDOW_DEPTH = 10,
    parameter int ADC_BITS     = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_W-1:0]       cfg_wr_data,      // samples_per_reading
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,     // [11:0] adc_sample
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,     // [14:0] average_density,
                                                     // [29:15] reading_density
    output logic [OUT_TUSER_W-1:0] m_axis_tuser      // [0] baseline_moved
);

    localparam int SAMPLE_W  = (ADC_BITS < SAMPLE_FIELD_W) ? ADC_BITS : SAMPLE_FIELD_W;
    localparam int TOTAL_W   = SAMPLE_W + CFG_W;
    localparam int FILL_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int HEAD_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int WSUM_W    = DENS_W + FILL_W;
    localparam int DIVD_W    = (TOTAL_W > WSUM_W) ? TOTAL_W : WSUM_W;
    localparam int DIV_W     = (CFG_W > FILL_W) ? CFG_W : FILL_W;
    localparam int CNT_W     = $clog2(DIVD_W + 1);
    localparam int PROD_W    = ADC_BITS + SCALE_W;
    localparam int BASE_RST  = ((2 ** ADC_BITS) * 25 + 165) / 330;
    localparam int ADC_MAX   = (2 ** ADC_BITS) - 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_MEAN,
        ST_MEAN,
        ST_MUL,
        ST_PUSH,
        ST_DIV_AVG,
        ST_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    spr_reg, spr_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [CFG_W-1:0]    count_reg, count_next;
    logic [ADC_BITS-1:0] base_reg, base_next;
    logic [ADC_BITS-1:0] diff_reg, diff_next;
    logic [DENS_W-1:0]   dens_reg, dens_next;
    logic                moved_reg, moved_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [HEAD_W-1:0]   head_reg, head_next;
    logic [WSUM_W-1:0]   wsum_reg, wsum_next;
    logic [DIVD_W-1:0]   quo_reg, quo_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [DENS_W-1:0]   out_avg_reg, out_avg_next;
    logic [DENS_W-1:0]   out_dens_reg, out_dens_next;
    logic                out_moved_reg, out_moved_next;

    logic [DENS_W-1:0]   window_mem [WINDOW_DEPTH];
    logic [DENS_W-1:0]   rd_data_reg;
    logic                mem_re;
    logic                mem_we;

    logic                in_accept;
    logic [SAMPLE_W-1:0] sample;
    logic [CFG_W-1:0]    burst_len;
    logic [TOTAL_W-1:0]  total_sum;
    logic [CFG_W-1:0]    count_inc;
    logic [DIV_W:0]      rem_shift;
    logic                rem_ge;
    logic [DIV_W-1:0]    step_rem;
    logic [DIVD_W-1:0]   step_quo;
    logic [ADC_BITS-1:0] mean;
    logic [PROD_W-1:0]   product;
    logic                window_full;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign sample        = s_axis_tdata[SAMPLE_W-1:0];
    assign burst_len     = (spr_reg == '0) ? CFG_W'(1) : spr_reg;
    assign total_sum     = total_reg + TOTAL_W'(sample);
    assign count_inc     = count_reg + CFG_W'(1);

    // One restoring division step
    assign rem_shift = {rem_reg, quo_reg[DIVD_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, dvs_reg});
    assign step_rem  = rem_ge ? DIV_W'(rem_shift - {1'b0, dvs_reg}) : rem_shift[DIV_W-1:0];
    assign step_quo  = {quo_reg[DIVD_W-2:0], rem_ge};

    assign mean        = (quo_reg > DIVD_W'(ADC_MAX)) ? ADC_BITS'(ADC_MAX)
                                                      : quo_reg[ADC_BITS-1:0];
    assign product     = PROD_W'(diff_reg) * PROD_W'(DENSITY_SCALE);
    assign window_full = (fill_reg == FILL_W'(WINDOW_DEPTH));

    assign mem_re = (state_reg == ST_MEAN);
    assign mem_we = (state_reg == ST_PUSH);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2 * DENS_W){1'b0}}, out_dens_reg, out_avg_reg};
    assign m_axis_tuser  = out_moved_reg;

    always_comb
    begin
        state_next     = state_reg;
        spr_next       = cfg_wr_en ? cfg_wr_data : spr_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        base_next      = base_reg;
        diff_next      = diff_reg;
        dens_next      = dens_reg;
        moved_next     = moved_reg;
        fill_next      = fill_reg;
        head_next      = head_reg;
        wsum_next      = wsum_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_avg_next   = out_avg_reg;
        out_dens_next  = out_dens_reg;
        out_moved_next = out_moved_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (count_inc >= burst_len)
                    begin
                        // burst complete: start mean division, clear the burst
                        quo_next   = DIVD_W'(total_sum);
                        rem_next   = '0;
                        dvs_next   = DIV_W'(burst_len);
                        cnt_next   = CNT_W'(DIVD_W);
                        total_next = '0;
                        count_next = '0;
                        state_next = ST_DIV_MEAN;
                    end
                    else
                    begin
                        total_next = total_sum;
                        count_next = count_inc;
                    end
                end
            end
            ST_DIV_MEAN:
            begin
                quo_next = step_quo;
                rem_next = step_rem;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                if (mean <= base_reg)
                begin
                    base_next  = mean;
                    dens_next  = DENS_W'(DENSITY_FLOOR);
                    moved_next = 1'b1;
                    state_next = ST_PUSH;
                end
                else
                begin
                    diff_next  = mean - base_reg;
                    moved_next = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                dens_next  = product[ADC_BITS +: DENS_W];
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                // oldest entry leaves the sum once the window is full
                if (window_full)
                begin
                    wsum_next = wsum_reg - WSUM_W'(rd_data_reg) + WSUM_W'(dens_reg);
                end
                else
                begin
                    wsum_next = wsum_reg + WSUM_W'(dens_reg);
                    fill_next = fill_reg + FILL_W'(1);
                end
                head_next  = (head_reg == HEAD_W'(WINDOW_DEPTH - 1)) ? '0
                                                                     : head_reg + HEAD_W'(1);
                quo_next   = DIVD_W'(wsum_next);
                rem_next   = '0;
                dvs_next   = DIV_W'(fill_next);
                cnt_next   = CNT_W'(DIVD_W);
                state_next = ST_DIV_AVG;
            end
            ST_DIV_AVG:
            begin
                quo_next = step_quo;
                rem_next = step_rem;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_avg_next   = quo_reg[DENS_W-1:0];
                    out_dens_next  = dens_reg;
                    out_moved_next = moved_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            spr_reg       <= CFG_W'(SPR_RESET);
            total_reg     <= '0;
            count_reg     <= '0;
            base_reg      <= ADC_BITS'(BASE_RST);
            diff_reg      <= '0;
            dens_reg      <= '0;
            moved_reg     <= 1'b0;
            fill_reg      <= '0;
            head_reg      <= '0;
            wsum_reg      <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            dvs_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_avg_reg   <= '0;
            out_dens_reg  <= '0;
            out_moved_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            spr_reg       <= spr_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            base_reg      <= base_next;
            diff_reg      <= diff_next;
            dens_reg      <= dens_next;
            moved_reg     <= moved_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            wsum_reg      <= wsum_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            dvs_reg       <= dvs_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_avg_reg   <= out_avg_next;
            out_dens_reg  <= out_dens_next;
            out_moved_reg <= out_moved_next;
        end
    end

    // Window store: read the oldest entry in the mean step, ahead of the write-back in the push step
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            window_mem[head_reg] <= dens_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= window_mem[head_reg];
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW_DEPTH))
        else $error("window fill beyond depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, head_reg} < (HEAD_W + 1)'(WINDOW_DEPTH))
        else $error("window head out of range");

    a_base_falls: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> base_reg <= $past(base_reg))
        else $error("baseline rose");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result word loaded outside the output step");

endmodule
